// ----- sv/usb_opp_pkg.sv -----
// Package: shared types and constants for the USB port overheat protection unit.
`timescale 1ns / 1ps
package usb_opp_pkg;

  localparam int unsigned CNT_W   = 12;
  localparam int unsigned DIFF_W  = 11;
  localparam int unsigned DELTA_W = 9;
  localparam int unsigned TEMP_W  = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [CNT_W-1:0] CNT_IDLE   = 12'hFFF;
  localparam logic [CNT_W-1:0] CNT_END    = 12'd1001;
  localparam logic [CNT_W-1:0] CNT_INSERT = 12'd1100;

  localparam logic signed [TEMP_W-1:0] TEMP_LOW  = -8'sd30;
  localparam logic signed [TEMP_W-1:0] TEMP_HIGH = 8'sd100;
  localparam logic signed [DIFF_W-1:0] BATT_INVALID = -11'sd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROTECT_EN    = 3'd0,
    CFG_PORT_THR      = 3'd1,
    CFG_CUTOFF_OPEN   = 3'd2,
    CFG_LIMIT_OPEN    = 3'd3,
    CFG_CUTOFF_CLOSE  = 3'd4,
    CFG_FAST_POLL     = 3'd5,
    CFG_LIMIT_REP_EN  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic                       protect_enable;
    logic signed [TEMP_W-1:0]   port_temp_threshold;
    logic signed [DELTA_W-1:0]  cutoff_open_delta;
    logic signed [DELTA_W-1:0]  limit_open_delta;
    logic signed [DELTA_W-1:0]  cutoff_close_delta;
    logic signed [DELTA_W-1:0]  fast_poll_delta;
    logic                       limit_report_enable;
  } cfg_t;

  typedef struct packed {
    logic                     operation;
    logic signed [TEMP_W-1:0] port_temp;
    logic signed [TEMP_W-1:0] batt_temp;
    logic                     batt_temp_valid;
    logic                     charger_absent;
  } item_t;

  typedef struct packed {
    logic cutoff_open;
    logic limit_on;
    logic protect_active;
    logic fast_poll;
    logic monitoring;
    logic limit_fault_report;
    logic cutoff_fault_report;
    logic stay_awake;
    logic temp_rejected;
  } result_t;

  function automatic logic signed [DIFF_W-1:0] ext_delta(logic signed [DELTA_W-1:0] d);
    ext_delta = {{(DIFF_W-DELTA_W){d[DELTA_W-1]}}, d};
  endfunction

  function automatic logic signed [DIFF_W-1:0] ext_temp(logic signed [TEMP_W-1:0] t);
    ext_temp = {{(DIFF_W-TEMP_W){t[TEMP_W-1]}}, t};
  endfunction

endpackage

// ----- sv/usb_opp_cfg.sv -----
// Configuration register file written through the plain write port.
`timescale 1ns / 1ps
module usb_opp_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [usb_opp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [usb_opp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output usb_opp_pkg::cfg_t                  cfg_o
);
  import usb_opp_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.protect_enable      <= 1'b0;
      cfg_q.port_temp_threshold <= 8'sd40;
      cfg_q.cutoff_open_delta   <= '0;
      cfg_q.limit_open_delta    <= '0;
      cfg_q.cutoff_close_delta  <= '0;
      cfg_q.fast_poll_delta     <= '0;
      cfg_q.limit_report_enable <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PROTECT_EN:   cfg_q.protect_enable      <= cfg_data_i[0];
        CFG_PORT_THR:     cfg_q.port_temp_threshold <= cfg_data_i[TEMP_W-1:0];
        CFG_CUTOFF_OPEN:  cfg_q.cutoff_open_delta   <= cfg_data_i[DELTA_W-1:0];
        CFG_LIMIT_OPEN:   cfg_q.limit_open_delta    <= cfg_data_i[DELTA_W-1:0];
        CFG_CUTOFF_CLOSE: cfg_q.cutoff_close_delta  <= cfg_data_i[DELTA_W-1:0];
        CFG_FAST_POLL:    cfg_q.fast_poll_delta     <= cfg_data_i[DELTA_W-1:0];
        CFG_LIMIT_REP_EN: cfg_q.limit_report_enable <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- sv/usb_opp_eval.sv -----
// Protection state registers and the single-pass update for one request.
`timescale 1ns / 1ps
module usb_opp_eval (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  usb_opp_pkg::cfg_t    cfg_i,
  input  usb_opp_pkg::item_t   item_i,
  input  logic                 adv_i,
  output usb_opp_pkg::result_t res_o
);
  import usb_opp_pkg::*;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic mon_q, mon_d;
  logic prot_q, prot_d;
  logic lim_q, lim_d;
  logic sw_q, sw_d;
  logic wake_q, wake_d;
  logic fast_q, fast_d;
  logic lim_arm_q, lim_arm_d;
  logic cut_arm_q, cut_arm_d;
  logic rep_lim, rep_cut, rejected;

  logic signed [DIFF_W-1:0] tusb_x, tbatt_x, diff_r, diff_a;
  logic hot, hot_a, range_bad;

  assign tusb_x  = ext_temp(item_i.port_temp);
  assign tbatt_x = ext_temp(item_i.batt_temp);
  // report / polling difference is zero without a valid battery reading
  assign diff_r  = item_i.batt_temp_valid ? (tusb_x - tbatt_x) : '0;
  assign diff_a  = item_i.batt_temp_valid ? diff_r : (tusb_x - BATT_INVALID);
  assign hot     = $signed(item_i.port_temp) >= $signed(cfg_i.port_temp_threshold);
  assign hot_a   = hot && item_i.batt_temp_valid;
  assign range_bad = ($signed(item_i.port_temp) < $signed(TEMP_LOW)) ||
                     ($signed(item_i.port_temp) > $signed(TEMP_HIGH));

  always_comb begin
    cnt_d     = cnt_q;
    mon_d     = mon_q;
    prot_d    = prot_q;
    lim_d     = lim_q;
    sw_d      = sw_q;
    wake_d    = wake_q;
    fast_d    = fast_q;
    lim_arm_d = lim_arm_q;
    cut_arm_d = cut_arm_q;
    rep_lim   = 1'b0;
    rep_cut   = 1'b0;
    rejected  = 1'b0;

    if (item_i.operation) begin
      if (cfg_i.protect_enable && !mon_q) begin
        cnt_d = CNT_INSERT;
        mon_d = 1'b1;
      end
    end else if (mon_q) begin
      if (cnt_q == CNT_IDLE && item_i.charger_absent) begin
        // charger gone after the window: disarm and re-arm reports
        cut_arm_d = 1'b1;
        lim_arm_d = 1'b1;
        sw_d      = 1'b0;
        fast_d    = 1'b0;
        prot_d    = 1'b0;
        cnt_d     = CNT_INSERT;
        mon_d     = 1'b0;
      end else if (range_bad) begin
        rejected = 1'b1;
      end else begin
        if (cfg_i.limit_report_enable && hot &&
            diff_r >= ext_delta(cfg_i.limit_open_delta) && lim_arm_q) begin
          rep_lim   = 1'b1;
          lim_arm_d = 1'b0;
        end
        if (hot && diff_r >= ext_delta(cfg_i.cutoff_open_delta) && cut_arm_q) begin
          rep_cut   = 1'b1;
          cut_arm_d = 1'b0;
        end

        // polling choice and settle window
        if (diff_r > ext_delta(cfg_i.fast_poll_delta)) begin
          fast_d = 1'b1;
          cnt_d  = '0;
        end else if (cnt_q == CNT_IDLE) begin
          fast_d = 1'b0;
          prot_d = 1'b0;
        end else if (cnt_q > CNT_END) begin
          cnt_d  = cnt_q - 1'b1;
          fast_d = 1'b1;
          prot_d = 1'b0;
        end else if (cnt_q == CNT_END) begin
          cnt_d  = CNT_IDLE;
          fast_d = 1'b0;
          prot_d = 1'b0;
          wake_d = 1'b0;
        end else begin
          cnt_d  = cnt_q + 1'b1;
          fast_d = 1'b1;
        end

        // switch and limit action, sees protect flag after polling update
        if (hot_a && diff_a >= ext_delta(cfg_i.limit_open_delta)) begin
          lim_d = 1'b1;
        end
        if (hot_a && diff_a >= ext_delta(cfg_i.cutoff_open_delta)) begin
          wake_d = 1'b1;
          prot_d = 1'b1;
          sw_d   = 1'b1;
        end else if (diff_a <= ext_delta(cfg_i.cutoff_close_delta)) begin
          if (prot_d) begin
            sw_d = 1'b0;
          end
          lim_d = 1'b0;
        end
      end
    end

    res_o.cutoff_open         = sw_d;
    res_o.limit_on            = lim_d;
    res_o.protect_active      = prot_d;
    res_o.fast_poll           = fast_d;
    res_o.monitoring          = mon_d;
    res_o.limit_fault_report  = rep_lim;
    res_o.cutoff_fault_report = rep_cut;
    res_o.stay_awake          = wake_d;
    res_o.temp_rejected       = rejected;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= CNT_INSERT;
      mon_q     <= 1'b0;
      prot_q    <= 1'b0;
      lim_q     <= 1'b0;
      sw_q      <= 1'b0;
      wake_q    <= 1'b0;
      fast_q    <= 1'b0;
      lim_arm_q <= 1'b1;
      cut_arm_q <= 1'b1;
    end else if (adv_i) begin
      cnt_q     <= cnt_d;
      mon_q     <= mon_d;
      prot_q    <= prot_d;
      lim_q     <= lim_d;
      sw_q      <= sw_d;
      wake_q    <= wake_d;
      fast_q    <= fast_d;
      lim_arm_q <= lim_arm_d;
      cut_arm_q <= cut_arm_d;
    end
  end

`ifndef SYNTHESIS
  // counter is reloaded whenever monitoring is off
  assert property (@(posedge clk_i) disable iff (!rst_ni) !mon_q |-> cnt_q == CNT_INSERT)
    else $error("settle counter not at insert value while monitoring is off");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_INSERT || cnt_q == CNT_IDLE)
    else $error("settle counter out of its reachable range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && res_o.cutoff_fault_report |=> !cut_arm_q)
    else $error("cutoff report did not disarm");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && res_o.temp_rejected |=>
      $stable(cnt_q) && $stable(sw_q) && $stable(lim_q) && $stable(prot_q))
    else $error("rejected tick changed protection state");
`endif

endmodule

// ----- sv/usb_port_overheat_protect_unit.sv -----
// Top level: request input register, evaluation stage and result register.
// An accepted request waits in the request register until its result is registered.
// Throughput: one request per cycle; a stalled result holds the request register,
// which then stalls the input.
// The state update for a request happens as it moves into the result register.
// Reset (async, active low) clears both valid flags, loads the settle counter to
// 1100, arms both fault reports and returns configuration to its defaults.
`timescale 1ns / 1ps
module usb_port_overheat_protect_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [usb_opp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [usb_opp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               operation_i,
  input  logic signed [usb_opp_pkg::TEMP_W-1:0] port_temp_i,
  input  logic signed [usb_opp_pkg::TEMP_W-1:0] batt_temp_i,
  input  logic                               batt_temp_valid_i,
  input  logic                               charger_absent_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               cutoff_open_o,
  output logic                               limit_on_o,
  output logic                               protect_active_o,
  output logic                               fast_poll_o,
  output logic                               monitoring_o,
  output logic                               limit_fault_report_o,
  output logic                               cutoff_fault_report_o,
  output logic                               stay_awake_o,
  output logic                               temp_rejected_o
);
  import usb_opp_pkg::*;

  cfg_t    cfg;
  item_t   in_q;
  logic    in_valid_q;
  result_t res, out_q;
  logic    out_valid_q;
  logic    adv, in_acc;

  usb_opp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_acc) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q.operation       <= operation_i;
      in_q.port_temp       <= port_temp_i;
      in_q.batt_temp       <= batt_temp_i;
      in_q.batt_temp_valid <= batt_temp_valid_i;
      in_q.charger_absent  <= charger_absent_i;
    end
  end

  usb_opp_eval u_eval (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .item_i (in_q),
    .adv_i  (adv),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign cutoff_open_o         = out_q.cutoff_open;
  assign limit_on_o            = out_q.limit_on;
  assign protect_active_o      = out_q.protect_active;
  assign fast_poll_o           = out_q.fast_poll;
  assign monitoring_o          = out_q.monitoring;
  assign limit_fault_report_o  = out_q.limit_fault_report;
  assign cutoff_fault_report_o = out_q.cutoff_fault_report;
  assign stay_awake_o          = out_q.stay_awake;
  assign temp_rejected_o       = out_q.temp_rejected;

endmodule

// ----- sim/overheat_tb_pkg.sv -----
// Package: request operation codes shared by the testbench files.
`timescale 1ns / 1ps
package overheat_tb_pkg;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_e;

endpackage

// ----- sim/overheat_checker.sv -----
// Checker: tracks the protection unit's state, predicts each status and compares it.
`timescale 1ns / 1ps
module overheat_checker
  import usb_opp_pkg::*;
  import overheat_tb_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic                     operation_i,
  input  logic signed [TEMP_W-1:0] port_temp_i,
  input  logic signed [TEMP_W-1:0] batt_temp_i,
  input  logic                     batt_temp_valid_i,
  input  logic                     charger_absent_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  result_t                  status_i,
  output int                       mismatch_count_o,
  output int                       pending_o
);

  cfg_t             cfg_q;
  logic [CNT_W-1:0] settle_cnt;
  logic             monitor_on;
  logic             protect_mode;
  logic             limit_mode;
  logic             switch_open;
  logic             wake_hold;
  logic             fast_mode;
  logic             limit_armed;
  logic             cutoff_armed;
  result_t          expected_status_q[$];

  task automatic reset_model();
    cfg_q.protect_enable      = 1'b0;
    cfg_q.port_temp_threshold = 8'sd40;
    cfg_q.cutoff_open_delta   = '0;
    cfg_q.limit_open_delta    = '0;
    cfg_q.cutoff_close_delta  = '0;
    cfg_q.fast_poll_delta     = '0;
    cfg_q.limit_report_enable = 1'b0;
    settle_cnt   = CNT_INSERT;
    monitor_on   = 1'b0;
    protect_mode = 1'b0;
    limit_mode   = 1'b0;
    switch_open  = 1'b0;
    wake_hold    = 1'b0;
    fast_mode    = 1'b0;
    limit_armed  = 1'b1;
    cutoff_armed = 1'b1;
    expected_status_q.delete();
    mismatch_count_o = 0;
    pending_o        = 0;
  endtask

  function automatic result_t predict_status(item_t req);
    result_t r;
    int      tusb, tbatt, thr, diff, act_diff;
    logic    hot, act_hot;
    r     = '0;
    tusb  = $signed(req.port_temp);
    tbatt = $signed(req.batt_temp);
    thr   = $signed(cfg_q.port_temp_threshold);
    if (req.operation == OP_START) begin
      if (cfg_q.protect_enable && !monitor_on) begin
        settle_cnt = CNT_INSERT;
        monitor_on = 1'b1;
      end
    end else if (monitor_on) begin
      if (settle_cnt == CNT_IDLE && req.charger_absent) begin
        // charger gone after the settle window: disarm; limit and wake hold stay
        cutoff_armed = 1'b1;
        limit_armed  = 1'b1;
        switch_open  = 1'b0;
        fast_mode    = 1'b0;
        protect_mode = 1'b0;
        settle_cnt   = CNT_INSERT;
        monitor_on   = 1'b0;
      end else if (tusb < TEMP_LOW || tusb > TEMP_HIGH) begin
        r.temp_rejected = 1'b1;
      end else begin
        diff = req.batt_temp_valid ? tusb - tbatt : 0;
        hot  = tusb >= thr;
        if (cfg_q.limit_report_enable && hot && limit_armed &&
            diff >= $signed(cfg_q.limit_open_delta)) begin
          r.limit_fault_report = 1'b1;
          limit_armed = 1'b0;
        end
        if (hot && cutoff_armed && diff >= $signed(cfg_q.cutoff_open_delta)) begin
          r.cutoff_fault_report = 1'b1;
          cutoff_armed = 1'b0;
        end
        // polling choice and settle window
        if (diff > $signed(cfg_q.fast_poll_delta)) begin
          fast_mode  = 1'b1;
          settle_cnt = '0;
        end else if (settle_cnt == CNT_IDLE) begin
          fast_mode    = 1'b0;
          protect_mode = 1'b0;
        end else if (settle_cnt > CNT_END) begin
          settle_cnt   = settle_cnt - 1'b1;
          fast_mode    = 1'b1;
          protect_mode = 1'b0;
        end else if (settle_cnt == CNT_END) begin
          settle_cnt   = CNT_IDLE;
          fast_mode    = 1'b0;
          protect_mode = 1'b0;
          wake_hold    = 1'b0;
        end else begin
          settle_cnt = settle_cnt + 1'b1;
          fast_mode  = 1'b1;
        end
        // switch and limit; an invalid battery reading blocks opening
        act_diff = tusb - (req.batt_temp_valid ? tbatt : int'(BATT_INVALID));
        act_hot  = req.batt_temp_valid && tusb >= thr;
        if (act_hot && act_diff >= $signed(cfg_q.limit_open_delta)) limit_mode = 1'b1;
        if (act_hot && act_diff >= $signed(cfg_q.cutoff_open_delta)) begin
          wake_hold    = 1'b1;
          protect_mode = 1'b1;
          switch_open  = 1'b1;
        end else if (act_diff <= $signed(cfg_q.cutoff_close_delta)) begin
          if (protect_mode) switch_open = 1'b0;
          limit_mode = 1'b0;
        end
      end
    end
    r.cutoff_open    = switch_open;
    r.limit_on       = limit_mode;
    r.protect_active = protect_mode;
    r.fast_poll      = fast_mode;
    r.monitoring     = monitor_on;
    r.stay_awake     = wake_hold;
    return r;
  endfunction

  task automatic check_field(string name, logic want, logic got);
    if (want !== got) begin
      if (mismatch_count_o < 200) begin
        $display("%0t ns: %s expected %0b actual %0b", $time, name, want, got);
      end
      mismatch_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    item_t   req;
    result_t want;
    if (!rst_ni) begin
      reset_model();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_status_q.size() == 0) begin
          if (mismatch_count_o < 200) begin
            $display("%0t ns: status with no request outstanding, actual %b", $time, status_i);
          end
          mismatch_count_o++;
        end else begin
          want = expected_status_q.pop_front();
          check_field("cutoff_open", want.cutoff_open, status_i.cutoff_open);
          check_field("limit_on", want.limit_on, status_i.limit_on);
          check_field("protect_active", want.protect_active, status_i.protect_active);
          check_field("fast_poll", want.fast_poll, status_i.fast_poll);
          check_field("monitoring", want.monitoring, status_i.monitoring);
          check_field("limit_fault_report", want.limit_fault_report,
                      status_i.limit_fault_report);
          check_field("cutoff_fault_report", want.cutoff_fault_report,
                      status_i.cutoff_fault_report);
          check_field("stay_awake", want.stay_awake, status_i.stay_awake);
          check_field("temp_rejected", want.temp_rejected, status_i.temp_rejected);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        req.operation       = operation_i;
        req.port_temp       = port_temp_i;
        req.batt_temp       = batt_temp_i;
        req.batt_temp_valid = batt_temp_valid_i;
        req.charger_absent  = charger_absent_i;
        expected_status_q.push_back(predict_status(req));
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_PROTECT_EN:   cfg_q.protect_enable      = cfg_data_i[0];
          CFG_PORT_THR:     cfg_q.port_temp_threshold = cfg_data_i[TEMP_W-1:0];
          CFG_CUTOFF_OPEN:  cfg_q.cutoff_open_delta   = cfg_data_i;
          CFG_LIMIT_OPEN:   cfg_q.limit_open_delta    = cfg_data_i;
          CFG_CUTOFF_CLOSE: cfg_q.cutoff_close_delta  = cfg_data_i;
          CFG_FAST_POLL:    cfg_q.fast_poll_delta     = cfg_data_i;
          CFG_LIMIT_REP_EN: cfg_q.limit_report_enable = cfg_data_i[0];
          default: ;
        endcase
      end
      pending_o = expected_status_q.size();
    end
  end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top: drives requests and settings into the protection unit, gives the verdict.
`timescale 1ns / 1ps
module tb_top;
  import usb_opp_pkg::*;
  import overheat_tb_pkg::*;

  localparam int HALF_PERIOD     = 5;
  localparam int QUIET_LIMIT     = 2000;
  localparam int PHASE_REQUESTS  = 175;
  localparam int RANDOM_PHASES   = 7;
  localparam int HOLD_OFF_CYCLES = 150;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     operation = 1'b0;
  logic signed [TEMP_W-1:0] port_temp = '0;
  logic signed [TEMP_W-1:0] batt_temp = '0;
  logic                     batt_temp_valid = 1'b0;
  logic                     charger_absent = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     pressure_go = 1'b0;
  wire cutoff_open, limit_on, protect_active, fast_poll, monitoring;
  wire limit_fault_report, cutoff_fault_report, stay_awake, temp_rejected;
  result_t status;
  int      mismatches;
  int      pending;
  int      burst_left = 0;
  int      requests_sent = 0;

  assign status = {cutoff_open, limit_on, protect_active, fast_poll, monitoring,
                   limit_fault_report, cutoff_fault_report, stay_awake, temp_rejected};

  always #HALF_PERIOD clk = ~clk;

  usb_port_overheat_protect_unit dut (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .cfg_we_i              (cfg_we),
    .cfg_index_i           (cfg_index),
    .cfg_data_i            (cfg_data),
    .in_valid_i            (in_valid),
    .in_stall_o            (in_stall),
    .operation_i           (operation),
    .port_temp_i           (port_temp),
    .batt_temp_i           (batt_temp),
    .batt_temp_valid_i     (batt_temp_valid),
    .charger_absent_i      (charger_absent),
    .out_valid_o           (out_valid),
    .out_stall_i           (out_stall),
    .cutoff_open_o         (cutoff_open),
    .limit_on_o            (limit_on),
    .protect_active_o      (protect_active),
    .fast_poll_o           (fast_poll),
    .monitoring_o          (monitoring),
    .limit_fault_report_o  (limit_fault_report),
    .cutoff_fault_report_o (cutoff_fault_report),
    .stay_awake_o          (stay_awake),
    .temp_rejected_o       (temp_rejected)
  );

  overheat_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .operation_i       (operation),
    .port_temp_i       (port_temp),
    .batt_temp_i       (batt_temp),
    .batt_temp_valid_i (batt_temp_valid),
    .charger_absent_i  (charger_absent),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .status_i          (status),
    .mismatch_count_o  (mismatches),
    .pending_o         (pending)
  );

  // Sender: bursts of random length separated by random gaps.
  task automatic send_request(op_e op, int pt, int bt, logic bv, logic ab);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid        <= 1'b1;
    operation       <= op;
    port_temp       <= pt[TEMP_W-1:0];
    batt_temp       <= bt[TEMP_W-1:0];
    batt_temp_valid <= bv;
    charger_absent  <= ab;
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  // Mostly plausible port temperatures; noise covers every field and operation.
  task automatic send_tick(logic noisy);
    int  pt;
    op_e op;
    op = noisy ? op_e'($urandom_range(0, 1)) : OP_TICK;
    if (!noisy && $urandom_range(0, 9) != 0) pt = int'($urandom_range(0, 130)) - 30;
    else pt = int'($urandom_range(0, 255)) - 128;
    send_request(op, pt, int'($urandom_range(0, 255)) - 128,
                 $urandom_range(0, 99) < 85, $urandom_range(0, 99) < 15);
  endtask

  task automatic write_reg(cfg_idx_e idx, int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
  endtask

  // Settings change only with nothing in flight; every result is counted in pending.
  task automatic apply_settings(logic en, int thr, int co, int lo, int cc, int fp, logic lr);
    @(negedge clk);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(negedge clk);
    write_reg(CFG_PROTECT_EN, int'(en));
    write_reg(CFG_PORT_THR, thr);
    write_reg(CFG_CUTOFF_OPEN, co);
    write_reg(CFG_LIMIT_OPEN, lo);
    write_reg(CFG_CUTOFF_CLOSE, cc);
    write_reg(CFG_FAST_POLL, fp);
    write_reg(CFG_LIMIT_REP_EN, int'(lr));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver: stall pattern of its own, plus one long hold-off to back up the unit.
  initial begin
    int   seg_left, mode, hold_left;
    logic hold_done;
    seg_left  = 0;
    mode      = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (pressure_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 3);
          seg_left = $urandom_range(10, 120);
        end
        seg_left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 30);
          2: out_stall <= ($urandom_range(0, 99) < 75);
          default: out_stall <= (seg_left % 3 == 0);
        endcase
      end
    end
  end

  // Watchdog on cycles with no request or status moving.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("[usb_port_overheat_protect_unit] ERROR");
    $finish;
  end

  initial begin
    int goal, run_len;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // defaults: protection off, so a start is ignored and ticks see monitoring off
    send_request(OP_START, 0, 0, 1'b1, 1'b0);
    send_request(OP_TICK, 60, 20, 1'b1, 1'b0);

    apply_settings(1'b1, 40, 10, 5, 2, 30, 1'b1);
    send_request(OP_START, 25, 25, 1'b1, 1'b0);
    send_request(OP_START, 25, 25, 1'b1, 1'b0);    // already armed
    send_request(OP_TICK, 127, 0, 1'b1, 1'b0);     // out of range
    send_request(OP_TICK, -128, 0, 1'b1, 1'b0);
    send_request(OP_TICK, 101, 0, 1'b1, 1'b0);
    send_request(OP_TICK, -31, 0, 1'b1, 1'b0);
    send_request(OP_TICK, -30, -128, 1'b1, 1'b0);  // big difference: fast poll restarts
    send_request(OP_TICK, 60, 40, 1'b1, 1'b0);     // both reports fire, switch opens
    send_request(OP_TICK, 60, 40, 1'b1, 1'b0);     // reports already spent
    send_request(OP_TICK, 100, 127, 1'b1, 1'b0);   // negative difference closes
    send_request(OP_TICK, 50, 0, 1'b0, 1'b0);      // battery reading invalid
    send_request(OP_TICK, 20, 127, 1'b1, 1'b1);    // charger gone but window not over
    send_request(OP_TICK, 45, -128, 1'b1, 1'b0);
    send_request(OP_TICK, 41, 39, 1'b0, 1'b1);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: apply_settings(1'b1, -128, -255, -255, -255, 255, 1'b1);
        1: apply_settings(1'b1, 127, 255, 255, 255, -255, 1'b0);
        2: apply_settings(1'b0, int'($urandom_range(0, 110)) - 20,
                          int'($urandom_range(0, 120)) - 60, int'($urandom_range(0, 120)) - 60,
                          int'($urandom_range(0, 120)) - 60, 255, 1'($urandom_range(0, 1)));
        default: apply_settings(1'b1, int'($urandom_range(0, 110)) - 20,
                                int'($urandom_range(0, 120)) - 60,
                                int'($urandom_range(0, 120)) - 60,
                                int'($urandom_range(0, 120)) - 60,
                                $urandom_range(0, 1) ? 255 : int'($urandom_range(0, 140)) - 60,
                                1'($urandom_range(0, 1)));
      endcase
      if (phase == 0) pressure_go <= 1'b1;
      goal = requests_sent + PHASE_REQUESTS;
      while (requests_sent < goal) begin
        if ($urandom_range(0, 99) < 85) begin
          // charger insertion followed by a run of monitoring ticks
          send_request(OP_START, int'($urandom_range(0, 255)) - 128,
                       int'($urandom_range(0, 255)) - 128, 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
          run_len = $urandom_range(20, 220);
          repeat (run_len) send_tick(1'b0);
        end else begin
          repeat ($urandom_range(1, 10)) send_tick(1'b1);
        end
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (6) @(negedge clk);
    if (mismatches == 0) begin
      $display("[usb_port_overheat_protect_unit] OK");
    end else begin
      $display("[usb_port_overheat_protect_unit] ERROR");
    end
    $finish;
  end

endmodule
